FILE: hw/rtl/spt_pkg.sv
// shared types, constants and control store for the sorted patch table
package spt_pkg;

   localparam int KeyW              = 32;
   localparam int ValueW            = 32;
   localparam int ReqTypeW          = 2;
   localparam int TableDepthDefault = 1024;

   localparam logic [ValueW-1:0] MissValue = {ValueW{1'b1}};

   typedef enum logic [ReqTypeW-1:0] {
      REQ_CLEAR  = 2'd0,
      REQ_INSERT = 2'd1,
      REQ_LOOKUP = 2'd2
   } req_code_type;

   typedef enum logic [2:0] {
      ST_CLEARED  = 3'd0,
      ST_INSERTED = 3'd1,
      ST_REPLACED = 3'd2,
      ST_LOOKUP   = 3'd3,
      ST_FULL     = 3'd4
   } status_type;

   typedef enum logic [4:0] {
      STEP_IDLE,
      STEP_DISPATCH,
      STEP_CLEAR,
      STEP_PROBE,
      STEP_NARROW,
      STEP_CHECK,
      STEP_DECIDE,
      STEP_LOOKUP,
      STEP_INS_MATCH,
      STEP_REPLACE,
      STEP_FULL_CHK,
      STEP_DROP,
      STEP_SHIFT_INIT,
      STEP_SHIFT_TEST,
      STEP_SHIFT_WR,
      STEP_PLACE,
      STEP_FINISH
   } step_type;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_LOAD,
      OP_CLEAR,
      OP_PROBE,
      OP_NARROW,
      OP_READ_POS,
      OP_LOOKUP,
      OP_REPLACE,
      OP_DROP,
      OP_IDX_INIT,
      OP_SHIFT_RD,
      OP_SHIFT_WR,
      OP_PLACE,
      OP_RESPOND
   } op_type;

   typedef enum logic [3:0] {
      COND_ALWAYS,
      COND_REQ_FIRE,
      COND_IS_CLEAR,
      COND_LO_LT_HI,
      COND_IS_INSERT,
      COND_MATCH,
      COND_FULL,
      COND_IDX_EQ_POS,
      COND_RSP_FREE
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type next_true;
      step_type next_false;
   } ucode_type;

   // control store: one word per step, two-way branch on the selected condition
   function automatic ucode_type ucode_rom(input step_type step);
      ucode_type w;
      unique case (step)
         STEP_IDLE:       w = '{OP_LOAD,     COND_REQ_FIRE,   STEP_DISPATCH,   STEP_IDLE};
         STEP_DISPATCH:   w = '{OP_NOP,      COND_IS_CLEAR,   STEP_CLEAR,      STEP_PROBE};
         STEP_CLEAR:      w = '{OP_CLEAR,    COND_ALWAYS,     STEP_FINISH,     STEP_FINISH};
         STEP_PROBE:      w = '{OP_PROBE,    COND_LO_LT_HI,   STEP_NARROW,     STEP_CHECK};
         STEP_NARROW:     w = '{OP_NARROW,   COND_ALWAYS,     STEP_PROBE,      STEP_PROBE};
         STEP_CHECK:      w = '{OP_READ_POS, COND_ALWAYS,     STEP_DECIDE,     STEP_DECIDE};
         STEP_DECIDE:     w = '{OP_NOP,      COND_IS_INSERT,  STEP_INS_MATCH,  STEP_LOOKUP};
         STEP_LOOKUP:     w = '{OP_LOOKUP,   COND_ALWAYS,     STEP_FINISH,     STEP_FINISH};
         STEP_INS_MATCH:  w = '{OP_NOP,      COND_MATCH,      STEP_REPLACE,    STEP_FULL_CHK};
         STEP_REPLACE:    w = '{OP_REPLACE,  COND_ALWAYS,     STEP_FINISH,     STEP_FINISH};
         STEP_FULL_CHK:   w = '{OP_NOP,      COND_FULL,       STEP_DROP,       STEP_SHIFT_INIT};
         STEP_DROP:       w = '{OP_DROP,     COND_ALWAYS,     STEP_FINISH,     STEP_FINISH};
         STEP_SHIFT_INIT: w = '{OP_IDX_INIT, COND_ALWAYS,     STEP_SHIFT_TEST, STEP_SHIFT_TEST};
         STEP_SHIFT_TEST: w = '{OP_SHIFT_RD, COND_IDX_EQ_POS, STEP_PLACE,      STEP_SHIFT_WR};
         STEP_SHIFT_WR:   w = '{OP_SHIFT_WR, COND_ALWAYS,     STEP_SHIFT_TEST, STEP_SHIFT_TEST};
         STEP_PLACE:      w = '{OP_PLACE,    COND_ALWAYS,     STEP_FINISH,     STEP_FINISH};
         STEP_FINISH:     w = '{OP_RESPOND,  COND_RSP_FREE,   STEP_IDLE,       STEP_FINISH};
         default:         w = '{OP_NOP,      COND_ALWAYS,     STEP_IDLE,       STEP_IDLE};
      endcase
      return w;
   endfunction

endpackage

FILE: hw/rtl/spt_channels.sv
// request and response channel interfaces of the sorted patch table
interface spt_req_if;
   import spt_pkg::*;
   logic                valid;
   logic                ready;
   logic [ReqTypeW-1:0] req_type;
   logic [KeyW-1:0]     key;
   logic [ValueW-1:0]   entry_value;

   modport source(output valid, req_type, key, entry_value, input ready);
   modport sink(input valid, req_type, key, entry_value, output ready);
endinterface

interface spt_rsp_if;
   import spt_pkg::*;
   logic              valid;
   logic              ready;
   status_type        status;
   logic              hit;
   logic [ValueW-1:0] found_value;

   modport source(output valid, status, hit, found_value, input ready);
   modport sink(input valid, status, hit, found_value, output ready);
endinterface

FILE: hw/rtl/sorted_patch_table_top.sv
// sorted key/value table with binary search, run by a microcoded sequencer
//
// The table holds up to TABLE_DEPTH pairs of a 32-bit key and a 32-bit value,
// sorted by ascending key, in two single-port-write, single-port-read memories
// with registered read data. One request is worked on at a time by a small
// program in a control store; a finished response sits in an output register,
// so the next request is taken while that response still waits for its
// transfer. A lookup or insert first finds the lower bound of its key by
// binary search, one memory probe per halving. An insert of a key already
// held replaces its value, an insert into a full table is dropped, and any
// other insert shifts every entry above the new key up by one through the
// single memory read port, one entry at a time, before placing the new pair.
// Request code 3 is treated as a lookup. Clear only zeroes the entry count,
// so it needs no pass over the memories, and there is no clearing pass after
// reset: entries are read only below the count.
module sorted_patch_table_top #(
   parameter int TABLE_DEPTH = spt_pkg::TableDepthDefault
) (
   input  logic      clock,
   input  logic      reset,
   spt_req_if.sink   req_chan,
   spt_rsp_if.source rsp_chan
);
   import spt_pkg::*;

   // address width for entries, count width that also holds the full depth
   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   // table storage
   logic [KeyW-1:0]   key_mem   [TABLE_DEPTH];
   logic [ValueW-1:0] value_mem [TABLE_DEPTH];

   // sequencer
   step_type  step_ff, step_in;
   ucode_type uc;
   logic      cond_true;

   // control state
   logic [CW-1:0] count_ff, count_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // datapath registers (no reset needed)
   logic [ReqTypeW-1:0] req_type_ff, req_type_in;
   logic [KeyW-1:0]     key_ff, key_in;
   logic [ValueW-1:0]   value_ff, value_in;
   logic [CW-1:0]       lo_ff, lo_in;
   logic [CW-1:0]       hi_ff, hi_in;
   logic [CW-1:0]       mid_ff, mid_in;
   logic [AW-1:0]       idx_ff, idx_in;
   status_type          status_ff, status_in;
   logic                hit_ff, hit_in;
   logic [ValueW-1:0]   found_ff, found_in;
   status_type          rsp_status_ff;
   logic                rsp_hit_ff;
   logic [ValueW-1:0]   rsp_found_ff;
   logic [KeyW-1:0]     key_rd_ff;
   logic [ValueW-1:0]   value_rd_ff;

   // memory port controls
   logic              key_we, value_we, mem_re;
   logic [AW-1:0]     mem_waddr, mem_raddr;
   logic [KeyW-1:0]   key_wdata;
   logic [ValueW-1:0] value_wdata;

   // decoded conditions
   logic req_fire, rsp_free, is_clear, is_insert, match, full, rsp_load;

   assign req_chan.ready = (step_ff == STEP_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   // output register is free when empty or being drained this cycle
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;
   assign is_clear       = (req_type_ff == REQ_CLEAR);
   assign is_insert      = (req_type_ff == REQ_INSERT);
   // key read at the lower-bound position matches the request key
   assign match          = (lo_ff < count_ff) && (key_rd_ff == key_ff);
   assign full           = (count_ff >= CW'(TABLE_DEPTH));

   assign uc = ucode_rom(step_ff);

   // branch condition select
   always_comb begin
      unique case (uc.cond)
         COND_ALWAYS:     cond_true = 1'b1;
         COND_REQ_FIRE:   cond_true = req_fire;
         COND_IS_CLEAR:   cond_true = is_clear;
         COND_LO_LT_HI:   cond_true = (lo_ff < hi_ff);
         COND_IS_INSERT:  cond_true = is_insert;
         COND_MATCH:      cond_true = match;
         COND_FULL:       cond_true = full;
         COND_IDX_EQ_POS: cond_true = (idx_ff == lo_ff[AW-1:0]);
         COND_RSP_FREE:   cond_true = rsp_free;
         default:         cond_true = 1'b1;
      endcase
      step_in = cond_true ? uc.next_true : uc.next_false;
   end

   // datapath driven by the current control word
   always_comb begin
      count_in    = count_ff;
      req_type_in = req_type_ff;
      key_in      = key_ff;
      value_in    = value_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      mid_in      = mid_ff;
      idx_in      = idx_ff;
      status_in   = status_ff;
      hit_in      = hit_ff;
      found_in    = found_ff;
      key_we      = 1'b0;
      value_we    = 1'b0;
      mem_re      = 1'b0;
      mem_waddr   = '0;
      mem_raddr   = '0;
      key_wdata   = key_ff;
      value_wdata = value_ff;
      rsp_load    = 1'b0;

      unique case (uc.op)
         OP_NOP: begin
         end
         OP_LOAD: begin
            // capture the request and open the search window over all entries
            if (req_fire) begin
               req_type_in = req_chan.req_type;
               key_in      = req_chan.key;
               value_in    = req_chan.entry_value;
               lo_in       = '0;
               hi_in       = count_ff;
               hit_in      = 1'b0;
               found_in    = MissValue;
            end
         end
         OP_CLEAR: begin
            count_in  = '0;
            status_in = ST_CLEARED;
         end
         OP_PROBE: begin
            // midpoint of the window, key read lands next cycle
            mid_in    = lo_ff + ((hi_ff - lo_ff) >> 1);
            mem_re    = 1'b1;
            mem_raddr = mid_in[AW-1:0];
         end
         OP_NARROW: begin
            if (key_rd_ff < key_ff) begin
               lo_in = mid_ff + CW'(1);
            end else begin
               hi_in = mid_ff;
            end
         end
         OP_READ_POS: begin
            // fetch the pair at the lower bound; ignored when past the end
            mem_re    = 1'b1;
            mem_raddr = lo_ff[AW-1:0];
         end
         OP_LOOKUP: begin
            status_in = ST_LOOKUP;
            hit_in    = match;
            found_in  = match ? value_rd_ff : MissValue;
         end
         OP_REPLACE: begin
            value_we  = 1'b1;
            mem_waddr = lo_ff[AW-1:0];
            status_in = ST_REPLACED;
         end
         OP_DROP: begin
            status_in = ST_FULL;
         end
         OP_IDX_INIT: begin
            // table not full here, so the count fits an address
            idx_in = count_ff[AW-1:0];
         end
         OP_SHIFT_RD: begin
            mem_re    = 1'b1;
            mem_raddr = idx_ff - AW'(1);
         end
         OP_SHIFT_WR: begin
            // move entry idx-1 up to idx
            key_we      = 1'b1;
            value_we    = 1'b1;
            mem_waddr   = idx_ff;
            key_wdata   = key_rd_ff;
            value_wdata = value_rd_ff;
            idx_in      = idx_ff - AW'(1);
         end
         OP_PLACE: begin
            key_we    = 1'b1;
            value_we  = 1'b1;
            mem_waddr = lo_ff[AW-1:0];
            count_in  = count_ff + CW'(1);
            status_in = ST_INSERTED;
         end
         OP_RESPOND: begin
            rsp_load = rsp_free;
         end
         default: begin
         end
      endcase
   end

   // output register valid: set by a load, dropped by a transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_type_ff <= req_type_in;
      key_ff      <= key_in;
      value_ff    <= value_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      mid_ff      <= mid_in;
      idx_ff      <= idx_in;
      status_ff   <= status_in;
      hit_ff      <= hit_in;
      found_ff    <= found_in;
      if (rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_hit_ff    <= hit_ff;
         rsp_found_ff  <= found_ff;
      end
   end

   // key memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[mem_waddr] <= key_wdata;
      end
      if (mem_re) begin
         key_rd_ff <= key_mem[mem_raddr];
      end
   end

   // value memory: same ports, shared addresses
   always_ff @(posedge clock) begin
      if (value_we) begin
         value_mem[mem_waddr] <= value_wdata;
      end
      if (mem_re) begin
         value_rd_ff <= value_mem[mem_raddr];
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.hit         = rsp_hit_ff;
   assign rsp_chan.found_value = rsp_found_ff;

endmodule

FILE: hw/rtl/spt_checker.sv
// port-level checks of the sorted patch table and their binding
module spt_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input spt_pkg::status_type       rsp_status,
   input logic                      rsp_hit,
   input logic [spt_pkg::ValueW-1:0] rsp_found_value
);
   import spt_pkg::*;

   // requests taken whose responses have not yet been transferred
   logic [1:0] pending_ff, pending_in;
   logic       req_xfer, rsp_xfer;

   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid && rsp_ready;

   always_comb begin
      pending_in = pending_ff;
      if (req_xfer && !rsp_xfer) begin
         pending_in = pending_ff + 2'd1;
      end else if (rsp_xfer && !req_xfer) begin
         pending_in = pending_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_rsp_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response valid dropped while stalled");

   a_rsp_payload_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(rsp_status) && $stable(rsp_hit) && $stable(rsp_found_value))
      else $error("response payload changed while stalled");

   a_no_unrequested_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 2'd0)
      else $error("response shown with no request pending");

   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_xfer |-> pending_ff <= 2'd1)
      else $error("request taken while one is still in work");

endmodule

bind sorted_patch_table_top spt_checker u_spt_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_status      (rsp_chan.status),
   .rsp_hit         (rsp_chan.hit),
   .rsp_found_value (rsp_chan.found_value)
);
